// File: rtl/abpc_pkg.sv
// Shared constants, types and helpers of the anchored base profile counter.
`default_nettype none

package abpc_pkg;

    // Sizes of the stores and counters
    localparam int SEQ_DEPTH     = 4096;
    localparam int WINDOW_DEPTH  = 256;
    localparam int WINDOW_CENTER = 128;
    localparam int COUNT_WIDTH   = 32;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int BASE_W     = 3;
    localparam int ANCHOR_W   = 12;
    localparam int OFF_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int UP_W       = 8;
    localparam int DN_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Derived widths
    localparam int SEQ_AW     = $clog2(SEQ_DEPTH);
    localparam int LEN_W      = SEQ_AW + 1;
    localparam int WIN_AW     = $clog2(WINDOW_DEPTH);
    // signed row arithmetic: center plus or minus a span or an offset
    localparam int RW         = $clog2(WINDOW_DEPTH + WINDOW_CENTER + (2 ** UP_W)) + 2;
    localparam int POS_BASE_W = (ANCHOR_W > RW) ? ANCHOR_W : RW;
    // sequence position of a window slot, negative values wrap high
    localparam int POS_W      = ((POS_BASE_W > LEN_W) ? POS_BASE_W : LEN_W) + 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_NEW   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FWD   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REV   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WINDOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REV  = 2'd2;

    // Register reset values
    localparam logic [UP_W-1:0] UP_RESET   = 8'd30;
    localparam logic [DN_W-1:0] DOWN_RESET = 7'd30;

    // Base codes (two low bits of a known base)
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_T = 2'd1;
    localparam logic [1:0] BASE_C = 2'd2;
    localparam logic [1:0] BASE_G = 2'd3;
    localparam logic [BASE_W-1:0] BASE_KNOWN_MAX = 3'd3;

    // One row of the frequency matrix
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] total;
        logic [COUNT_WIDTH-1:0] a;
        logic [COUNT_WIDTH-1:0] t;
        logic [COUNT_WIDTH-1:0] c;
        logic [COUNT_WIDTH-1:0] g;
    } t_row;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic step;        // issue one window slot of the walk
        logic read_issue;  // read the row for a read row request
        logic out_load;    // load the result register
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic rev_enable;  // reverse anchors are counted
        logic walk_empty;  // current spans leave no slot in the matrix
        logic walk_last;   // slot being issued is the last one
    } t_dp_stat;

    // Saturating increment
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(
        input logic [COUNT_WIDTH-1:0] v,
        input logic                   en
    );
        logic [COUNT_WIDTH-1:0] r;
        r = v;
        if (en && (v != '1)) begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/abpc_ctrl.sv
// Controller state machine: sequences requests, anchor walks and result hand-off.
`default_nettype none

module abpc_ctrl import abpc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    input  wire logic             i_out_stall,
    input  wire t_dp_stat         i_stat,
    output t_ctl_cmd              o_ctl,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_READ  = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    t_ctl_cmd w_ctl;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.accept = 1'b1;
                    priority if ((i_cmd == CMD_FWD) ||
                                 ((i_cmd == CMD_REV) && i_stat.rev_enable)) begin
                        n_state = i_stat.walk_empty ? S_RESP : S_WALK;
                    end else if (i_cmd == CMD_READ) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_WALK: begin
                w_ctl.step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last slot's counter update lands here
            S_DRAIN: begin
                n_state = S_RESP;
            end
            S_READ: begin
                w_ctl.read_issue = 1'b1;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, dropped when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctl       = w_ctl;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/abpc_dp.sv
// Datapath: config registers, sequence store, matrix memory, tallies and result register.
`default_nettype none

module abpc_dp import abpc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_ctl_cmd               i_ctl,
    output t_dp_stat                    o_stat,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // request fields
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic [BASE_W-1:0]      i_base,
    input  wire logic [ANCHOR_W-1:0]    i_anchor_pos,
    input  wire logic signed [OFF_W-1:0] i_row_offset,
    // result fields
    output logic [STATUS_W-1:0]         o_status,
    output logic [COUNT_WIDTH-1:0]      o_row_total,
    output logic [COUNT_WIDTH-1:0]      o_row_a,
    output logic [COUNT_WIDTH-1:0]      o_row_t,
    output logic [COUNT_WIDTH-1:0]      o_row_c,
    output logic [COUNT_WIDTH-1:0]      o_row_g,
    output logic [COUNT_WIDTH-1:0]      o_seq_a_total,
    output logic [COUNT_WIDTH-1:0]      o_seq_t_total,
    output logic [COUNT_WIDTH-1:0]      o_seq_c_total,
    output logic [COUNT_WIDTH-1:0]      o_seq_g_total,
    output logic [COUNT_WIDTH-1:0]      o_anchors_seen
);

    // Config registers
    logic [UP_W-1:0] r_up;
    logic [DN_W-1:0] r_down;
    logic            r_rev_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up     <= UP_RESET;
            r_down   <= DOWN_RESET;
            r_rev_en <= 1'b1;
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == CFG_UP) begin
                r_up <= i_cfg_data[UP_W-1:0];
            end else if (i_cfg_index == CFG_DOWN) begin
                r_down <= i_cfg_data[DN_W-1:0];
            end else if (i_cfg_index == CFG_REV) begin
                r_rev_en <= i_cfg_data[0];
            end
        end
    end

    // Decoded request
    logic w_is_load, w_is_new, w_is_fwd, w_is_rev, w_is_read, w_is_clear;
    logic w_full, w_known, w_counted;
    assign w_is_new   = i_ctl.accept && (i_cmd == CMD_NEW);
    assign w_is_load  = i_ctl.accept && (i_cmd == CMD_LOAD);
    assign w_is_fwd   = i_ctl.accept && (i_cmd == CMD_FWD);
    assign w_is_rev   = i_ctl.accept && (i_cmd == CMD_REV);
    assign w_is_read  = i_ctl.accept && (i_cmd == CMD_READ);
    assign w_is_clear = i_ctl.accept && (i_cmd == CMD_CLEAR);
    assign w_known    = (i_base <= BASE_KNOWN_MAX);
    assign w_counted  = w_is_fwd || (w_is_rev && r_rev_en);

    // Window bounds, clamped to the matrix
    logic signed [RW-1:0] w_start_s, w_end_s;
    always_comb begin
        w_start_s = $signed(RW'(WINDOW_CENTER)) - $signed(RW'(r_up));
        w_end_s   = $signed(RW'(WINDOW_CENTER)) + $signed(RW'(r_down));
        if (w_start_s < 0) begin
            w_start_s = '0;
        end
        if (w_end_s > $signed(RW'(WINDOW_DEPTH - 1))) begin
            w_end_s = $signed(RW'(WINDOW_DEPTH - 1));
        end
    end

    // Row read window check
    logic signed [RW-1:0] w_off_s, w_rrow_s;
    logic                 w_bad;
    assign w_off_s  = RW'(i_row_offset);
    assign w_rrow_s = $signed(RW'(WINDOW_CENTER)) + w_off_s;
    assign w_bad    = (w_off_s < -$signed(RW'(r_up))) ||
                      (w_off_s > $signed(RW'(r_down))) ||
                      (w_rrow_s < 0) ||
                      (w_rrow_s > $signed(RW'(WINDOW_DEPTH - 1)));

    // Sequence length and store full
    logic [LEN_W-1:0] r_seq_len;
    assign w_full = (r_seq_len == LEN_W'(SEQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= '0;
        end else if (w_is_new) begin
            r_seq_len <= '0;
        end else if (w_is_load && !w_full) begin
            r_seq_len <= r_seq_len + 1'b1;
        end
    end

    // Latched request payload
    logic [WIN_AW-1:0]   r_row, r_row_end, r_rd_row;
    logic [ANCHOR_W-1:0] r_anchor;
    logic                r_rev, r_is_read, r_bad;
    logic [STATUS_W-1:0] r_item_status;

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_row     <= w_start_s[WIN_AW-1:0];
            r_row_end <= w_end_s[WIN_AW-1:0];
            r_anchor  <= i_anchor_pos;
            r_rev     <= (i_cmd == CMD_REV);
            r_is_read <= (i_cmd == CMD_READ);
            r_bad     <= w_bad;
            r_rd_row  <= w_rrow_s[WIN_AW-1:0];
            priority if (w_is_load && w_full) begin
                r_item_status <= ST_FULL;
            end else if (w_is_read && w_bad) begin
                r_item_status <= ST_WINDOW;
            end else begin
                r_item_status <= ST_OK;
            end
        end else if (i_ctl.step) begin
            r_row <= r_row + 1'b1;
        end
    end

    // Sequence position of the slot being issued (mirrored for reverse)
    logic signed [RW-1:0] w_rel;
    logic [POS_W-1:0]     w_rel_p, w_pos;
    logic                 w_hit;
    assign w_rel   = $signed(RW'(r_row)) - $signed(RW'(WINDOW_CENTER));
    assign w_rel_p = POS_W'(w_rel);
    assign w_pos   = r_rev ? (POS_W'(r_anchor) - w_rel_p) : (POS_W'(r_anchor) + w_rel_p);
    // negative positions wrap above any length
    assign w_hit   = (w_pos < POS_W'(r_seq_len));

    // Sequence store
    logic [BASE_W-1:0] r_base_mem [SEQ_DEPTH];
    logic [BASE_W-1:0] r_rd_base;

    always_ff @(posedge i_clk) begin
        if (w_is_load && !w_full) begin
            r_base_mem[r_seq_len[SEQ_AW-1:0]] <= i_base;
        end
        if (i_ctl.step) begin
            r_rd_base <= r_base_mem[w_pos[SEQ_AW-1:0]];
        end
    end

    // Matrix memory: read stage then update stage, one slot per cycle
    t_row              r_row_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_row_vld;
    t_row              r_rd_data;
    logic              r_rd_vld;
    logic              r_s_hit;
    logic [WIN_AW-1:0] r_s_row;
    logic [WIN_AW-1:0] w_rd_addr;
    logic              w_rd_en;

    assign w_rd_en   = i_ctl.step || i_ctl.read_issue;
    assign w_rd_addr = i_ctl.step ? r_row : r_rd_row;

    // Update stage: saturating add of total and base count
    t_row       w_cur, w_new;
    logic       w_b_known;
    logic [1:0] w_b_idx;
    always_comb begin
        w_cur     = r_rd_vld ? r_rd_data : '0;
        w_b_known = (r_rd_base <= BASE_KNOWN_MAX);
        w_b_idx   = r_rd_base[1:0] ^ {1'b0, r_rev};
        w_new.total = sat_inc(w_cur.total, 1'b1);
        w_new.a     = sat_inc(w_cur.a, w_b_known && (w_b_idx == BASE_A));
        w_new.t     = sat_inc(w_cur.t, w_b_known && (w_b_idx == BASE_T));
        w_new.c     = sat_inc(w_cur.c, w_b_known && (w_b_idx == BASE_C));
        w_new.g     = sat_inc(w_cur.g, w_b_known && (w_b_idx == BASE_G));
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_row_mem[w_rd_addr];
            r_rd_vld  <= r_row_vld[w_rd_addr];
        end
        if (i_ctl.step) begin
            r_s_row <= r_row;
        end
        if (r_s_hit) begin
            r_row_mem[r_s_row] <= w_new;
        end
    end

    // Row valid bits and the update stage flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_s_hit   <= 1'b0;
        end else begin
            r_s_hit <= i_ctl.step && w_hit;
            if (w_is_clear) begin
                r_row_vld <= '0;
            end else if (r_s_hit) begin
                r_row_vld[r_s_row] <= 1'b1;
            end
        end
    end

    // Composition and anchor tallies
    logic [COUNT_WIDTH-1:0] r_tally_a, r_tally_t, r_tally_c, r_tally_g, r_anchors;
    logic                   w_tally_en;
    assign w_tally_en = w_is_load && !w_full && w_known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_is_clear) begin
            r_tally_a <= '0;
            r_tally_t <= '0;
            r_tally_c <= '0;
            r_tally_g <= '0;
            r_anchors <= '0;
        end else begin
            r_tally_a <= sat_inc(r_tally_a, w_tally_en && (i_base[1:0] == BASE_A));
            r_tally_t <= sat_inc(r_tally_t, w_tally_en && (i_base[1:0] == BASE_T));
            r_tally_c <= sat_inc(r_tally_c, w_tally_en && (i_base[1:0] == BASE_C));
            r_tally_g <= sat_inc(r_tally_g, w_tally_en && (i_base[1:0] == BASE_G));
            r_anchors <= sat_inc(r_anchors, w_counted);
        end
    end

    // Result register
    t_row w_out_row;
    assign w_out_row = (r_is_read && !r_bad && r_rd_vld) ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_status       <= r_item_status;
            o_row_total    <= w_out_row.total;
            o_row_a        <= w_out_row.a;
            o_row_t        <= w_out_row.t;
            o_row_c        <= w_out_row.c;
            o_row_g        <= w_out_row.g;
            o_seq_a_total  <= r_tally_a;
            o_seq_t_total  <= r_tally_t;
            o_seq_c_total  <= r_tally_c;
            o_seq_g_total  <= r_tally_g;
            o_anchors_seen <= r_anchors;
        end
    end

    // Status to controller
    assign o_stat.rev_enable = r_rev_en;
    assign o_stat.walk_empty = (w_start_s > w_end_s);
    assign o_stat.walk_last  = (r_row == r_row_end);

endmodule

`default_nettype wire

// File: rtl/anchored_base_profile_counter.sv
// Top level of the anchored base profile counter: controller, datapath and checks.
`default_nettype none

// Builds a position frequency matrix around anchor sites. One request is
// worked at a time and every request gives one result; a new request is
// taken while the previous result still waits in the output register.
// A forward anchor, or a reverse one while reverse_enable is set, walks
// the window slots inside the matrix (min(upstream_span, 128) +
// downstream_span + 1 slots): after taking the request the matrix memory
// does one read-modify-write per slot, read and update overlapped across
// slots, then the last update lands and the result is loaded. A read row
// reads its row before the result is loaded. Statistics clear through
// per-row valid bits; no clearing pass after reset.
// Registers: 0 upstream_span, 1 downstream_span, 2 reverse_enable.

module anchored_base_profile_counter import abpc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [BASE_W-1:0]       i_base,
    input  wire logic [ANCHOR_W-1:0]     i_anchor_pos,
    input  wire logic signed [OFF_W-1:0] i_row_offset,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [STATUS_W-1:0]          o_status,
    output logic [COUNT_WIDTH-1:0]       o_row_total,
    output logic [COUNT_WIDTH-1:0]       o_row_a,
    output logic [COUNT_WIDTH-1:0]       o_row_t,
    output logic [COUNT_WIDTH-1:0]       o_row_c,
    output logic [COUNT_WIDTH-1:0]       o_row_g,
    output logic [COUNT_WIDTH-1:0]       o_seq_a_total,
    output logic [COUNT_WIDTH-1:0]       o_seq_t_total,
    output logic [COUNT_WIDTH-1:0]       o_seq_c_total,
    output logic [COUNT_WIDTH-1:0]       o_seq_g_total,
    output logic [COUNT_WIDTH-1:0]       o_anchors_seen
);

    t_ctl_cmd w_ctl;
    t_dp_stat w_stat;

    // Controller
    abpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Datapath
    abpc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_base         (i_base),
        .i_anchor_pos   (i_anchor_pos),
        .i_row_offset   (i_row_offset),
        .o_status       (o_status),
        .o_row_total    (o_row_total),
        .o_row_a        (o_row_a),
        .o_row_t        (o_row_t),
        .o_row_c        (o_row_c),
        .o_row_g        (o_row_g),
        .o_seq_a_total  (o_seq_a_total),
        .o_seq_t_total  (o_seq_t_total),
        .o_seq_c_total  (o_seq_c_total),
        .o_seq_g_total  (o_seq_g_total),
        .o_anchors_seen (o_anchors_seen)
    );

    // A taken request closes the request channel until its result is loaded
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request channel open right after a request was taken");

    // Result register never overwrites an unconsumed result
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled result");

    // Walk steps only while a request is in progress
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.step |-> o_in_stall)
        else $error("walk step while idle");

    // An out-of-window read reports an empty row; its total, A and G counts are checked
    a_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_WINDOW)) |->
            ((o_row_total == '0) && (o_row_a == '0) && (o_row_g == '0)))
        else $error("out-of-window read returned row data");

endmodule

`default_nettype wire
